FILE: sv/dtr_pkg.sv
// ---------------------------------------------------------------------------
// dtr_pkg
// Types, constants and the control store for the divider timer sequencer.
// ---------------------------------------------------------------------------
package dtr_pkg;

    // bus map of the timer registers
    localparam logic [15:0] ADDR_DIV  = 16'hFF04;
    localparam logic [15:0] ADDR_TIMA = 16'hFF05;
    localparam logic [15:0] ADDR_TMA  = 16'hFF06;
    localparam logic [15:0] ADDR_TAC  = 16'hFF07;

    localparam logic [7:0] TAC_READ_MASK = 8'hF8;
    localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;
    localparam logic [7:0] COUNTER_MAX   = 8'hFF;

    // opcodes of an input item
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam int unsigned PC_W   = 3;
    localparam int unsigned TICK_W = 10;  // width of the remaining clock tick count

    typedef logic [PC_W-1:0] t_pc;

    // program steps
    localparam t_pc PC_FETCH = 3'd0;
    localparam t_pc PC_TICK  = 3'd1;
    localparam t_pc PC_READ  = 3'd2;
    localparam t_pc PC_WRITE = 3'd3;
    localparam t_pc PC_DONE  = 3'd4;

    // jump conditions
    typedef logic [1:0] t_cond;
    localparam t_cond COND_ALWAYS   = 2'd0;
    localparam t_cond COND_DISPATCH = 2'd1;
    localparam t_cond COND_LAST     = 2'd2;
    localparam t_cond COND_OUT_FREE = 2'd3;

    typedef struct packed {
        logic  accept;   // take an input transfer
        logic  tick;     // advance one clock tick
        logic  rd;       // bus read into result
        logic  wr;       // bus write
        logic  emit;     // load result into output register
        t_cond cond;
        t_pc   target;   // taken when cond holds, unless cond is dispatch
        t_pc   next_pc;  // taken otherwise
    } t_uop;

    function automatic t_uop uop_rom(input t_pc pc);
        t_uop u;
        u = '0;
        case (pc)
            PC_FETCH: begin
                u.accept  = 1'b1;
                u.cond    = COND_DISPATCH;
                u.target  = PC_DONE;
                u.next_pc = PC_FETCH;
            end
            PC_TICK: begin
                u.tick    = 1'b1;
                u.cond    = COND_LAST;
                u.target  = PC_DONE;
                u.next_pc = PC_TICK;
            end
            PC_READ: begin
                u.rd      = 1'b1;
                u.cond    = COND_ALWAYS;
                u.target  = PC_DONE;
                u.next_pc = PC_DONE;
            end
            PC_WRITE: begin
                u.wr      = 1'b1;
                u.cond    = COND_ALWAYS;
                u.target  = PC_DONE;
                u.next_pc = PC_DONE;
            end
            PC_DONE: begin
                u.emit    = 1'b1;
                u.cond    = COND_OUT_FREE;
                u.target  = PC_FETCH;
                u.next_pc = PC_DONE;
            end
            default: begin
                u.cond    = COND_ALWAYS;
                u.target  = PC_FETCH;
                u.next_pc = PC_FETCH;
            end
        endcase
        return u;
    endfunction

endpackage

FILE: sv/divider_timer_with_reload_unit.sv
// ---------------------------------------------------------------------------
// divider_timer_with_reload_unit
// Timer peripheral: 16-bit divider, 8-bit counter with modulo reload,
// driven by a microcoded sequencer with a small control store.
// ---------------------------------------------------------------------------
// sequence: a read or write item runs its read or write step, then the done step;
//   a tick item repeats the tick step (one clock tick per cycle) until its tick
//   count runs out, then goes to done; a zero-length tick or unused opcode goes straight to done
// throughput: one item at a time; the sequencer returns to the fetch step once
//   the result is loaded into the output register
// reset: synchronous active low, clears all timer state and the sequencer
module divider_timer_with_reload_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [7:0]  i_cycle_count,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic        o_interrupt_raised
);
    import dtr_pkg::*;

    t_pc               r_pc;
    t_uop              w_uop;
    logic              w_take;
    t_pc               w_dispatch;

    logic [15:0]       r_divider;
    logic [7:0]        r_counter;
    logic [7:0]        r_modulo;
    logic [2:0]        r_control;
    logic              r_prev_bit;

    logic [1:0]        r_opcode;
    logic [15:0]       r_address;
    logic [7:0]        r_write_data;
    logic [TICK_W-1:0] r_remaining;
    logic [7:0]        r_rd_data;
    logic              r_irq;
    logic              r_out_valid;

    logic [15:0]       n_divider;
    logic              w_cur_bit;
    logic              w_fall;
    logic              w_out_free;
    logic              w_cond;

    assign w_uop      = uop_rom(r_pc);
    assign o_in_ready = w_uop.accept;
    assign o_out_valid = r_out_valid;
    assign w_out_free = !r_out_valid || i_out_ready;

    // opcode dispatch, zero-length ticks and unused opcode go straight to done
    always_comb begin
        case (i_opcode)
            OP_TICK:  w_dispatch = (i_cycle_count == 8'd0) ? PC_DONE : PC_TICK;
            OP_READ:  w_dispatch = PC_READ;
            OP_WRITE: w_dispatch = PC_WRITE;
            default:  w_dispatch = PC_DONE;
        endcase
    end

    assign w_take = w_uop.accept && i_in_valid;

    always_comb begin
        case (w_uop.cond)
            COND_ALWAYS:   w_cond = 1'b1;
            COND_DISPATCH: w_cond = i_in_valid;
            COND_LAST:     w_cond = (r_remaining == TICK_W'(1));
            COND_OUT_FREE: w_cond = w_out_free;
            default:       w_cond = 1'b1;
        endcase
    end

    // one clock tick of the divider and edge detect on the watched bit
    assign n_divider = r_divider + 16'd1;
    always_comb begin
        case (r_control[1:0])
            2'd0:    w_cur_bit = n_divider[9];
            2'd1:    w_cur_bit = n_divider[3];
            2'd2:    w_cur_bit = n_divider[5];
            default: w_cur_bit = n_divider[7];
        endcase
        w_cur_bit = w_cur_bit && r_control[2];
    end
    assign w_fall = r_prev_bit && !w_cur_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_FETCH;
            r_divider   <= '0;
            r_counter   <= '0;
            r_modulo    <= '0;
            r_control   <= '0;
            r_prev_bit  <= 1'b0;
            r_out_valid <= 1'b0;
            r_irq       <= 1'b0;
            r_rd_data   <= '0;
        end else begin
            if (w_uop.cond == COND_DISPATCH) begin
                r_pc <= w_cond ? w_dispatch : w_uop.next_pc;
            end else begin
                r_pc <= w_cond ? w_uop.target : w_uop.next_pc;
            end

            if (w_take) begin
                r_opcode     <= i_opcode;
                r_address    <= i_address;
                r_write_data <= i_write_data;
                r_remaining  <= {i_cycle_count, 2'b00};
                r_rd_data    <= '0;
                r_irq        <= 1'b0;
            end

            if (w_uop.tick) begin
                r_divider   <= n_divider;
                r_prev_bit  <= w_cur_bit;
                r_remaining <= r_remaining - TICK_W'(1);
                if (w_fall) begin
                    if (r_counter == COUNTER_MAX) begin
                        r_counter <= r_modulo;
                        r_irq     <= 1'b1;
                    end else begin
                        r_counter <= r_counter + 8'd1;
                    end
                end
            end

            if (w_uop.rd) begin
                case (r_address)
                    ADDR_DIV:  r_rd_data <= r_divider[15:8];
                    ADDR_TIMA: r_rd_data <= r_counter;
                    ADDR_TMA:  r_rd_data <= r_modulo;
                    ADDR_TAC:  r_rd_data <= {5'b0, r_control} | TAC_READ_MASK;
                    default:   r_rd_data <= UNMAPPED_BYTE;
                endcase
            end

            if (w_uop.wr) begin
                case (r_address)
                    ADDR_DIV:  r_divider <= '0;
                    ADDR_TIMA: r_counter <= r_write_data;
                    ADDR_TMA:  r_modulo  <= r_write_data;
                    ADDR_TAC:  r_control <= r_write_data[2:0];
                    default:   ;
                endcase
            end

            // output register, freed by its transfer
            if (w_uop.emit && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, opcode only used to keep non-tick items irq-free
    always_ff @(posedge i_clk) begin
        if (w_uop.emit && w_out_free) begin
            o_read_data        <= r_rd_data;
            o_interrupt_raised <= r_irq && (r_opcode == OP_TICK);
        end
    end

endmodule
